// ===== sv/yab_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yab_pkg
// shared types, coefficients and helpers of the yuv alpha blend pixel block
// ----------------------------------------------------------------------------
package yab_pkg;

    localparam int CfgIndexW = 1;
    localparam int CfgDataW  = 9;

    localparam logic [CfgIndexW-1:0] CFG_BLEND_WEIGHT = 1'd0;
    localparam logic [CfgIndexW-1:0] CFG_BLEND_MODE   = 1'd1;

    localparam logic MODE_FADE    = 1'b0;
    localparam logic MODE_OVERLAY = 1'b1;

    localparam logic [8:0] WEIGHT_RESET = 9'd128;
    localparam logic [8:0] WEIGHT_MAX   = 9'd256;

    // q16 coefficients, yuv to rgb
    localparam logic [15:0] K_RV = 16'd9175;
    localparam logic [15:0] K_GU = 16'd25821;
    localparam logic [15:0] K_GV = 16'd5308;
    localparam logic [15:0] K_BU = 16'd2097;
    // q16 coefficients, rgb to yuv
    localparam logic [15:0] K_YR = 16'd19595;
    localparam logic [15:0] K_YG = 16'd5701;
    localparam logic [15:0] K_YB = 16'd7471;
    localparam logic [15:0] K_UR = 16'd9633;
    localparam logic [15:0] K_UG = 16'd18939;
    localparam logic [15:0] K_UB = 16'd28573;
    localparam logic [15:0] K_VR = 16'd7536;
    localparam logic [15:0] K_VG = 16'd983;
    localparam logic [15:0] K_VB = 16'd6553;

    typedef struct packed {
        logic signed [11:0] r;
        logic signed [11:0] g;
        logic signed [11:0] b;
    } t_rgb;

    // floor(x * k / 65536)
    function automatic logic signed [12:0] hi16(input logic signed [11:0] x,
                                                input logic [15:0] k);
        logic signed [28:0] p;
        p = 29'(x) * 29'($signed({1'b0, k}));
        return p[28:16];
    endfunction

    function automatic logic [7:0] sat8(input logic signed [13:0] v);
        logic [7:0] res;
        if (v < 14'sd0) begin
            res = 8'd0;
        end else if (v > 14'sd255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== sv/yab_rgb_conv.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yab_rgb_conv
// yuv sample triple to rgb with q16 high-half products, full width result
// ----------------------------------------------------------------------------
module yab_rgb_conv (
    input  var logic [7:0]    i_luma,
    input  var logic [7:0]    i_cb,
    input  var logic [7:0]    i_cr,
    output yab_pkg::t_rgb     o_rgb
);

    logic signed [12:0] y13;
    logic signed [12:0] u13;
    logic signed [12:0] v13;
    logic signed [12:0] r13;
    logic signed [12:0] g13;
    logic signed [12:0] b13;

    always_comb begin
        y13 = {5'd0, i_luma};
        u13 = {5'd0, i_cb} - 13'sd128;
        v13 = {5'd0, i_cr} - 13'sd128;
        r13 = y13 + v13 + yab_pkg::hi16(v13[11:0], yab_pkg::K_RV);
        g13 = y13 - yab_pkg::hi16(u13[11:0], yab_pkg::K_GU) - (v13 >>> 1)
              - yab_pkg::hi16(v13[11:0], yab_pkg::K_GV);
        b13 = y13 + (u13 <<< 1) + yab_pkg::hi16(u13[11:0], yab_pkg::K_BU);
        o_rgb.r = r13[11:0];
        o_rgb.g = g13[11:0];
        o_rgb.b = b13[11:0];
    end

endmodule
`default_nettype wire

// ===== sv/yuv_alpha_blend_pixel_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuv_alpha_blend_pixel_top
// alpha blend of two yuv 4:2:0 pixels through rgb, when not stalled one pixel per clock
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_stall, one beat carries the luma and the chroma
//   of both images for one pixel plus the chroma site flag.
//   output channel: o_valid / i_stall, one beat carries the blended luma,
//   chroma and the chroma valid flag; chroma reads zero off chroma sites.
//   config: i_cfg_wr_en with i_cfg_index and i_cfg_wdata, index 0 is the
//   blend weight (values above 256 act as 256), index 1 the blend mode
//   (0 fade, 1 overlay). write only while the pipeline is empty.
//   throughput: one beat per clock while the output is not stalled;
//   three register stages (yuv to rgb, weighted blend, rgb to yuv with
//   saturation) each hold one pixel.
//   reset: synchronous, clears the pipeline valid bits, weight goes to 128
//   and mode to fade.
//   stall: a stalled output holds its beat; the stall backs up stage by
//   stage, empty stages still fill, and o_stall rises only when all three
//   stages are full and the output is stalled.
// ----------------------------------------------------------------------------
module yuv_alpha_blend_pixel_top (
    input  var logic                             i_clk,
    input  var logic                             i_rst_n,
    input  var logic                             i_cfg_wr_en,
    input  var logic [yab_pkg::CfgIndexW-1:0]    i_cfg_index,
    input  var logic [yab_pkg::CfgDataW-1:0]     i_cfg_wdata,
    input  var logic                             i_valid,
    output var logic                             o_stall,
    input  var logic [7:0]                       i_luma_first,
    input  var logic [7:0]                       i_cb_first,
    input  var logic [7:0]                       i_cr_first,
    input  var logic [7:0]                       i_luma_second,
    input  var logic [7:0]                       i_cb_second,
    input  var logic [7:0]                       i_cr_second,
    input  var logic                             i_chroma_site,
    output var logic                             o_valid,
    input  var logic                             i_stall,
    output var logic [7:0]                       o_luma_out,
    output var logic [7:0]                       o_cb_out,
    output var logic [7:0]                       o_cr_out,
    output var logic                             o_chroma_valid
);

    function automatic logic signed [11:0] blend_ch(input logic signed [11:0] c1,
                                                    input logic signed [11:0] c2,
                                                    input logic [8:0] a,
                                                    input logic mode);
        logic signed [9:0]  a1;
        logic signed [9:0]  a2;
        logic signed [19:0] p1;
        logic signed [19:0] p2;
        logic signed [19:0] sum;
        a1  = {1'b0, a};
        a2  = {1'b0, yab_pkg::WEIGHT_MAX - a};
        p1  = 20'(a1) * 20'(c1);
        p2  = 20'(a2) * 20'(c2);
        sum = (mode == yab_pkg::MODE_OVERLAY) ? (p1 + p2) : p1;
        return sum[19:8];
    endfunction

    // config registers
    logic [8:0] r_weight;
    logic       r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= yab_pkg::WEIGHT_RESET;
            r_mode   <= yab_pkg::MODE_FADE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                yab_pkg::CFG_BLEND_WEIGHT: r_weight <= i_cfg_wdata;
                yab_pkg::CFG_BLEND_MODE:   r_mode   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // stage flow control
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic ready1;
    logic ready2;
    logic ready3;

    assign ready3  = !r_v3 || !i_stall;
    assign ready2  = !r_v2 || ready3;
    assign ready1  = !r_v1 || ready2;
    assign o_stall = !ready1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= i_valid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // stage 1: yuv to rgb for both images
    yab_pkg::t_rgb rgb_first;
    yab_pkg::t_rgb rgb_second;
    yab_pkg::t_rgb r_rgb1;
    yab_pkg::t_rgb r_rgb2;
    logic          r_site1;

    yab_rgb_conv u_conv_first (
        .i_luma (i_luma_first),
        .i_cb   (i_cb_first),
        .i_cr   (i_cr_first),
        .o_rgb  (rgb_first)
    );

    yab_rgb_conv u_conv_second (
        .i_luma (i_luma_second),
        .i_cb   (i_cb_second),
        .i_cr   (i_cr_second),
        .o_rgb  (rgb_second)
    );

    always_ff @(posedge i_clk) begin
        if (ready1) begin
            r_rgb1  <= rgb_first;
            r_rgb2  <= rgb_second;
            r_site1 <= i_chroma_site;
        end
    end

    // stage 2: weighted blend
    logic [8:0]    alpha;
    yab_pkg::t_rgb n_mix;
    yab_pkg::t_rgb r_mix;
    logic          r_site2;

    always_comb begin
        alpha   = (r_weight > yab_pkg::WEIGHT_MAX) ? yab_pkg::WEIGHT_MAX : r_weight;
        n_mix.r = blend_ch(r_rgb1.r, r_rgb2.r, alpha, r_mode);
        n_mix.g = blend_ch(r_rgb1.g, r_rgb2.g, alpha, r_mode);
        n_mix.b = blend_ch(r_rgb1.b, r_rgb2.b, alpha, r_mode);
    end

    always_ff @(posedge i_clk) begin
        if (ready2) begin
            r_mix   <= n_mix;
            r_site2 <= r_site1;
        end
    end

    // stage 3: rgb to yuv, saturate
    logic signed [13:0] g_half;
    logic signed [13:0] r_half;
    logic signed [13:0] y_sum;
    logic signed [13:0] u_sum;
    logic signed [13:0] v_sum;
    logic [7:0]         n_luma;
    logic [7:0]         n_cb;
    logic [7:0]         n_cr;
    logic [7:0]         r_luma;
    logic [7:0]         r_cb;
    logic [7:0]         r_cr;
    logic               r_site3;

    always_comb begin
        g_half = 14'(r_mix.g) >>> 1;
        r_half = 14'(r_mix.r) >>> 1;
        y_sum  = 14'(yab_pkg::hi16(r_mix.r, yab_pkg::K_YR))
                 + 14'(yab_pkg::hi16(r_mix.g, yab_pkg::K_YG)) + g_half
                 + 14'(yab_pkg::hi16(r_mix.b, yab_pkg::K_YB));
        u_sum  = 14'(yab_pkg::hi16(r_mix.b, yab_pkg::K_UB))
                 - 14'(yab_pkg::hi16(r_mix.g, yab_pkg::K_UG))
                 - 14'(yab_pkg::hi16(r_mix.r, yab_pkg::K_UR)) + 14'sd128;
        v_sum  = 14'(yab_pkg::hi16(r_mix.r, yab_pkg::K_VR)) + r_half
                 - (14'(yab_pkg::hi16(r_mix.g, yab_pkg::K_VG)) + g_half)
                 - 14'(yab_pkg::hi16(r_mix.b, yab_pkg::K_VB)) + 14'sd128;
        n_luma = yab_pkg::sat8(y_sum);
        n_cb   = r_site2 ? yab_pkg::sat8(u_sum) : 8'd0;
        n_cr   = r_site2 ? yab_pkg::sat8(v_sum) : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (ready3) begin
            r_luma  <= n_luma;
            r_cb    <= n_cb;
            r_cr    <= n_cr;
            r_site3 <= r_site2;
        end
    end

    assign o_valid        = r_v3;
    assign o_luma_out     = r_luma;
    assign o_cb_out       = r_cb;
    assign o_cr_out       = r_cr;
    assign o_chroma_valid = r_site3;

    // checks
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && i_stall))
        else $error("input stalled while a stage is free");

    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !ready3) |=> (r_v2 && $stable(r_mix) && $stable(r_site2)))
        else $error("blend stage lost a held pixel");

    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_chroma_valid) |-> (o_cb_out == 8'd0 && o_cr_out == 8'd0))
        else $error("chroma not zero off a chroma site");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_v1 && !r_v2 && !r_v3))
        else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for yuv_alpha_blend_pixel_top: pixels of two images go in
// through a queue-fed driver, each accepted beat is blended by an in-bench
// model under the current weight and mode, and a monitor compares every output
// beat in order; both sides idle at random in most phases, and the weight and mode change
// between phases while the pipeline is empty
// ----------------------------------------------------------------------------
module tb;

    localparam int   PHASES       = 12;
    localparam int   PHASE_BEATS  = 80;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] cb_first;
        logic [7:0] cr_first;
        logic [7:0] luma_second;
        logic [7:0] cb_second;
        logic [7:0] cr_second;
        logic       chroma_site;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
        logic       chroma_valid;
    } t_pixel_out;

    typedef struct {
        longint r;
        longint g;
        longint b;
    } t_rgb_full;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_wr_en = 1'b0;
    logic [yab_pkg::CfgIndexW-1:0] i_cfg_index = yab_pkg::CFG_BLEND_WEIGHT;
    logic [yab_pkg::CfgDataW-1:0]  i_cfg_wdata = '0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [7:0]                    i_luma_first = '0;
    logic [7:0]                    i_cb_first = '0;
    logic [7:0]                    i_cr_first = '0;
    logic [7:0]                    i_luma_second = '0;
    logic [7:0]                    i_cb_second = '0;
    logic [7:0]                    i_cr_second = '0;
    logic                          i_chroma_site = 1'b0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [7:0]                    o_luma_out;
    logic [7:0]                    o_cb_out;
    logic [7:0]                    o_cr_out;
    logic                          o_chroma_valid;

    t_pixel_in  pixel_q[$];
    t_pixel_out blended_q[$];
    t_pixel_in  cur_px;
    logic [8:0] weight_cfg = yab_pkg::WEIGHT_RESET;
    logic       mode_cfg = yab_pkg::MODE_FADE;
    int         src_pace = 1;
    int         sink_pace = 1;
    int         gap_left = 0;
    int         stall_left = 0;
    int         mismatch_count = 0;

    yuv_alpha_blend_pixel_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_luma_first   (i_luma_first),
        .i_cb_first     (i_cb_first),
        .i_cr_first     (i_cr_first),
        .i_luma_second  (i_luma_second),
        .i_cb_second    (i_cb_second),
        .i_cr_second    (i_cr_second),
        .i_chroma_site  (i_chroma_site),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_luma_out     (o_luma_out),
        .o_cb_out       (o_cb_out),
        .o_cr_out       (o_cr_out),
        .o_chroma_valid (o_chroma_valid)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // floor(x * k / 65536), arithmetic shift floors negatives
    function automatic longint q16_hi(longint x, longint k);
        return (x * k) >>> 16;
    endfunction

    function automatic logic [7:0] clamp_byte(longint v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    function automatic t_rgb_full yuv_to_rgb(logic [7:0] y8, logic [7:0] u8, logic [7:0] v8);
        longint    y;
        longint    u;
        longint    v;
        t_rgb_full c;
        y = y8;
        u = u8;
        v = v8;
        u = u - 128;
        v = v - 128;
        c.r = y + v + q16_hi(v, yab_pkg::K_RV);
        c.g = y - q16_hi(u, yab_pkg::K_GU) - (v >>> 1) - q16_hi(v, yab_pkg::K_GV);
        c.b = y + 2 * u + q16_hi(u, yab_pkg::K_BU);
        return c;
    endfunction

    function automatic longint mix(longint a, logic mode, longint c1, longint c2);
        if (mode == yab_pkg::MODE_OVERLAY) return (a * c1 + (256 - a) * c2) >>> 8;
        return (a * c1) >>> 8;
    endfunction

    function automatic t_pixel_out blend_pixel(t_pixel_in px, logic [8:0] weight, logic mode);
        longint     a;
        t_rgb_full  c1;
        t_rgb_full  c2;
        longint     r;
        longint     g;
        longint     b;
        t_pixel_out res;
        a = (weight > yab_pkg::WEIGHT_MAX) ? longint'(yab_pkg::WEIGHT_MAX) : longint'(weight);
        c1 = yuv_to_rgb(px.luma_first, px.cb_first, px.cr_first);
        c2 = yuv_to_rgb(px.luma_second, px.cb_second, px.cr_second);
        r = mix(a, mode, c1.r, c2.r);
        g = mix(a, mode, c1.g, c2.g);
        b = mix(a, mode, c1.b, c2.b);
        res.luma = clamp_byte(q16_hi(r, yab_pkg::K_YR) + q16_hi(g, yab_pkg::K_YG)
                              + (g >>> 1) + q16_hi(b, yab_pkg::K_YB));
        res.cb = 8'd0;
        res.cr = 8'd0;
        res.chroma_valid = px.chroma_site;
        if (px.chroma_site) begin
            res.cb = clamp_byte(q16_hi(b, yab_pkg::K_UB) - q16_hi(g, yab_pkg::K_UG)
                                - q16_hi(r, yab_pkg::K_UR) + 128);
            res.cr = clamp_byte(q16_hi(r, yab_pkg::K_VR) + (r >>> 1)
                                - q16_hi(g, yab_pkg::K_VG) - (g >>> 1)
                                - q16_hi(b, yab_pkg::K_VB) + 128);
        end
        return res;
    endfunction

    // mostly short gaps, a few long ones, none at pace 0
    function automatic int idle_len(int pace);
        int r;
        if (pace == 0) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [7:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        if (r == 2) return 8'd128;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_pixel_in mk_px(int y1, int u1, int v1, int y2, int u2, int v2,
                                        int site);
        t_pixel_in px;
        px.luma_first = 8'(y1);
        px.cb_first = 8'(u1);
        px.cr_first = 8'(v1);
        px.luma_second = 8'(y2);
        px.cb_second = 8'(u2);
        px.cr_second = 8'(v2);
        px.chroma_site = 1'(site);
        return px;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [yab_pkg::CfgIndexW-1:0] idx,
                             input logic [yab_pkg::CfgDataW-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == yab_pkg::CFG_BLEND_WEIGHT) begin
            weight_cfg = data;
        end else begin
            mode_cfg = data[0];
        end
    endtask

    task automatic set_blend(input logic [8:0] weight, input logic mode);
        logic [yab_pkg::CfgDataW-1:0] d;
        d = yab_pkg::CfgDataW'($urandom);
        d[0] = mode;
        write_reg(yab_pkg::CFG_BLEND_WEIGHT, weight);
        write_reg(yab_pkg::CFG_BLEND_MODE, d);
    endtask

    // sender holds off until every expected beat is back and the pipe is empty
    task automatic wait_drained();
        while (pixel_q.size() != 0 || i_valid || gap_left != 0 || blended_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic push_corner_pixels();
        pixel_q.push_back(mk_px(0, 0, 0, 255, 255, 255, 1));
        pixel_q.push_back(mk_px(255, 255, 255, 0, 0, 0, 1));
        pixel_q.push_back(mk_px(0, 128, 128, 255, 128, 128, 0));
        pixel_q.push_back(mk_px(255, 0, 255, 0, 255, 0, 1));
        pixel_q.push_back(mk_px(0, 255, 0, 255, 0, 255, 1));
        pixel_q.push_back(mk_px(128, 128, 128, 128, 128, 128, 1));
        pixel_q.push_back(mk_px(255, 0, 0, 255, 0, 0, 0));
        pixel_q.push_back(mk_px(0, 255, 255, 0, 255, 255, 1));
        pixel_q.push_back(mk_px(16, 128, 128, 235, 240, 16, 1));
        pixel_q.push_back(mk_px(255, 255, 0, 0, 0, 255, 0));
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                blended_q.push_back(blend_pixel(cur_px, weight_cfg, mode_cfg));
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    cur_px = pixel_q.pop_front();
                    i_luma_first <= cur_px.luma_first;
                    i_cb_first <= cur_px.cb_first;
                    i_cr_first <= cur_px.cr_first;
                    i_luma_second <= cur_px.luma_second;
                    i_cb_second <= cur_px.cb_second;
                    i_cr_second <= cur_px.cr_second;
                    i_chroma_site <= cur_px.chroma_site;
                    i_valid <= 1'b1;
                    gap_left = idle_len(src_pace);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : sink
        t_pixel_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (blended_q.size() == 0) begin
                report_mismatch("beat with no pixel pending, luma", o_luma_out, -1);
            end else begin
                want = blended_q.pop_front();
                if (o_luma_out !== want.luma) report_mismatch("luma", o_luma_out, want.luma);
                if (o_cb_out !== want.cb) report_mismatch("cb", o_cb_out, want.cb);
                if (o_cr_out !== want.cr) report_mismatch("cr", o_cr_out, want.cr);
                if (o_chroma_valid !== want.chroma_valid) begin
                    report_mismatch("chroma valid", o_chroma_valid, want.chroma_valid);
                end
            end
        end
        if (stall_left == 0) stall_left = idle_len(sink_pace);
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [8:0] phase_weight[PHASES];
        logic       phase_mode[PHASES];
        logic [8:0] w;
        t_pixel_in  px;
        phase_weight = '{9'd0, 9'd256, 9'd300, 9'd128, 9'd0, 9'd256,
                         9'd511, 9'd1, 9'd255, 9'd64, 9'd0, 9'd0};
        phase_mode = '{yab_pkg::MODE_FADE, yab_pkg::MODE_FADE, yab_pkg::MODE_FADE,
                       yab_pkg::MODE_OVERLAY, yab_pkg::MODE_OVERLAY,
                       yab_pkg::MODE_OVERLAY, yab_pkg::MODE_OVERLAY,
                       yab_pkg::MODE_OVERLAY, yab_pkg::MODE_FADE,
                       yab_pkg::MODE_OVERLAY, yab_pkg::MODE_OVERLAY,
                       yab_pkg::MODE_FADE};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // corner pixels under the reset weight and mode, then in overlay
        push_corner_pixels();
        wait_drained();
        set_blend(yab_pkg::WEIGHT_RESET, yab_pkg::MODE_OVERLAY);
        push_corner_pixels();
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            w = (p >= PHASES - 2) ? 9'($urandom_range(0, 511)) : phase_weight[p];
            set_blend(w, phase_mode[p]);
            src_pace = (p % 4 == 2) ? 0 : 1;
            sink_pace = (p % 4 == 2 || p % 5 == 1) ? 0 : 1;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                px.luma_first = rand_sample();
                px.cb_first = rand_sample();
                px.cr_first = rand_sample();
                px.luma_second = rand_sample();
                px.cb_second = rand_sample();
                px.cr_second = rand_sample();
                px.chroma_site = 1'($urandom_range(0, 1));
                pixel_q.push_back(px);
            end
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
